[src/mlsf_pkg.sv]
// ----------------------------------------------------------------------------
// mlsf_pkg
// shared types for the smallest-factor split block
// ----------------------------------------------------------------------------
package mlsf_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_WAIT
   } state_type;

endpackage

[src/min_lcm_split_by_smallest_factor_core.sv]
// ----------------------------------------------------------------------------
// min_lcm_split_by_smallest_factor_core
// splits n into its largest proper divisor a and n - a by trial division
// trial divisors p run from 2 upward until p divides n or p > n / p
// each trial is one launch state plus a wait for the shared divider to finish
// one item at a time: start is taken only when idle, and busy falls with the strobe
// the receiver cannot stall: rsp_valid is a single-cycle strobe
// reset (synchronous) returns the sequencer to idle and clears the strobe
// ----------------------------------------------------------------------------
module min_lcm_split_by_smallest_factor_core #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [WIDTH-1:0] req_number,
   output logic             rsp_valid,
   output logic [WIDTH-1:0] rsp_part_a,
   output logic [WIDTH-1:0] rsp_part_b
);

   import mlsf_pkg::*;

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] num_ff, num_in;
   logic [WIDTH-1:0] p_ff, p_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic             valid_ff, valid_in;
   logic             div_start;
   logic             div_done;
   logic [WIDTH-1:0] div_quotient;
   logic [WIDTH-1:0] div_remainder;
   logic [WIDTH-1:0] a_sel;
   logic             finish;

   mlsf_divider #(
      .WIDTH(WIDTH)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (num_ff),
      .div_divisor  (p_ff),
      .div_done     (div_done),
      .div_quotient (div_quotient),
      .div_remainder(div_remainder)
   );

   always_comb begin
      state_in  = state_ff;
      num_in    = num_ff;
      p_in      = p_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      valid_in  = 1'b0;
      div_start = 1'b0;
      finish    = 1'b0;
      a_sel     = WIDTH'(1);
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = req_number;
               p_in     = WIDTH'(2);
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            div_start = 1'b1;
            state_in  = ST_WAIT;
         end
         ST_WAIT: begin
            if (div_done) begin
               priority if (p_ff > div_quotient) begin
                  finish = 1'b1;
               end else if (div_remainder == '0) begin
                  a_sel  = div_quotient;
                  finish = 1'b1;
               end else begin
                  p_in     = p_ff + 1'b1;
                  state_in = ST_LAUNCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         a_in     = a_sel;
         b_in     = num_ff - a_sel;
         valid_in = 1'b1;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      p_ff   <= p_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_valid  = valid_ff;
   assign rsp_part_a = a_ff;
   assign rsp_part_b = b_ff;

endmodule

[src/mlsf_divider.sv]
// ----------------------------------------------------------------------------
// mlsf_divider
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mlsf_divider #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             div_start,
   input  logic [WIDTH-1:0] div_dividend,
   input  logic [WIDTH-1:0] div_divisor,
   output logic             div_done,
   output logic [WIDTH-1:0] div_quotient,
   output logic [WIDTH-1:0] div_remainder
);

   localparam int CW = $clog2(WIDTH);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   assign shifted = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH - 1);
         rem_in  = '0;
         quo_in  = div_dividend;
         dvs_in  = div_divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_done      = done_ff;
   assign div_quotient  = quo_ff;
   assign div_remainder = rem_ff;

endmodule
